// File: src/bhpq_pkg.sv
// ============================================================================
// bhpq_pkg
// Shared constants, operation and status codes, and the command and status
// structures that join the heap controller to its datapath.
// ============================================================================
package bhpq_pkg;

    // Default sizing of the heap.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 16;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Status codes returned with every result item.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY_POP = 2'd1;
    localparam logic [1:0] STAT_FULL_DROP = 2'd2;
    localparam logic [1:0] STAT_BAD_POS   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the input item and start the operation
        logic rd_up;     // read the parent of the hole
        logic up_step;   // compare with the parent, move it down or place
        logic pop_load;  // latch root and last entry, open a hole at the root
        logic rd_dn;     // read both children of the hole
        logic dn_step;   // compare with the better child, move it up or place
        logic wr_val;    // place the travelling value into the hole
        logic rd_load;   // latch the entry read for a read operation
        logic finish;    // load the result item into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;       // mode of the item offered at the input
        logic       full;       // heap holds its capacity
        logic       empty;      // heap holds nothing
        logic       pos_bad;    // offered read position is out of range
        logic       is_root;    // hole sits at the root
        logic       up_better;  // travelling value beats its parent
        logic       count_one;  // exactly one entry held
        logic       left_ok;    // hole has at least a left child
        logic       dn_better;  // better child beats the travelling value
        logic       out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

// File: src/bhpq_req_if.sv
// ============================================================================
// bhpq_req_if
// Request channel of the heap: valid/ready handshake carrying one operation.
// ============================================================================
interface bhpq_req_if #(
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH,
    parameter int POS_WIDTH  = $clog2(bhpq_pkg::DEF_CAPACITY + 1)
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_WIDTH-1:0]  position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// File: src/bhpq_rsp_if.sv
// ============================================================================
// bhpq_rsp_if
// Response channel of the heap: valid/ready handshake carrying one result.
// ============================================================================
interface bhpq_rsp_if #(
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH,
    parameter int POS_WIDTH  = $clog2(bhpq_pkg::DEF_CAPACITY + 1)
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result_value;
    logic [1:0]            status;
    logic [POS_WIDTH-1:0]  entry_count;

    modport source (output valid, output result_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                    output ready);
endinterface

// File: src/bhpq_ctrl.sv
// ============================================================================
// bhpq_ctrl
// Heap controller: sequences insert, pop, read and clear over the datapath,
// one memory access round per state.
// ============================================================================
module bhpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  bhpq_pkg::t_dp_stat i_stat,
    output bhpq_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_CHK  = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_POP_LD  = 4'd3;
    localparam logic [3:0] ST_DN_CHK  = 4'd4;
    localparam logic [3:0] ST_DN_CMP  = 4'd5;
    localparam logic [3:0] ST_RD_WAIT = 4'd6;
    localparam logic [3:0] ST_FIN     = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // The controller takes a new item only when no operation is in flight.
    assign o_req_ready = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_stat.mode)
                        bhpq_pkg::MODE_INSERT: n_state = i_stat.full ? ST_FIN : ST_UP_CHK;
                        bhpq_pkg::MODE_POP:    n_state = i_stat.empty ? ST_FIN : ST_POP_LD;
                        bhpq_pkg::MODE_READ:   n_state = i_stat.pos_bad ? ST_FIN : ST_RD_WAIT;
                        default:               n_state = ST_FIN;
                    endcase
                end
            end
            ST_UP_CHK: begin
                if (i_stat.is_root) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                o_cmd.up_step = 1'b1;
                n_state       = i_stat.up_better ? ST_UP_CHK : ST_FIN;
            end
            ST_POP_LD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = i_stat.count_one ? ST_FIN : ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (i_stat.left_ok) begin
                    o_cmd.rd_dn = 1'b1;
                    n_state     = ST_DN_CMP;
                end else begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = ST_FIN;
                end
            end
            ST_DN_CMP: begin
                o_cmd.dn_step = 1'b1;
                n_state       = i_stat.dn_better ? ST_DN_CHK : ST_FIN;
            end
            ST_RD_WAIT: begin
                o_cmd.rd_load = 1'b1;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/bhpq_dp.sv
// ============================================================================
// bhpq_dp
// Heap datapath: entry memory, fill count, hole position, travelling value,
// the order compares and the output register.
// ============================================================================
module bhpq_dp #(
    parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH,
    parameter int POS_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic [1:0]            i_mode,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [POS_W-1:0]      i_position,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [DATA_WIDTH-1:0] o_result_value,
    output logic [1:0]            o_status,
    output logic [POS_W-1:0]      o_entry_count,
    input  bhpq_pkg::t_dp_cmd     i_cmd,
    output bhpq_pkg::t_dp_stat    o_stat
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Entry memory, position p is stored at address p-1.
    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic                  r_order_max;
    logic [POS_W-1:0]      r_count;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_res;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_rd0;
    logic [DATA_WIDTH-1:0] r_rd1;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [1:0]            r_out_status;
    logic [POS_W-1:0]      r_out_count;

    logic [POS_W:0]        left_pos;
    logic [POS_W:0]        right_pos;
    logic [POS_W:0]        left_m1;
    logic [POS_W-1:0]      pos_m1;
    logic [POS_W-1:0]      parent_m1;
    logic [POS_W-1:0]      req_pos_m1;
    logic [POS_W-1:0]      count_m1;
    logic [POS_W-1:0]      count_p1;
    logic                  left_ok;
    logic                  right_ok;
    logic                  full;
    logic                  empty;
    logic                  pos_bad;
    logic                  up_better;
    logic                  right_pick;
    logic                  dn_better;
    logic [DATA_WIDTH-1:0] pick_data;
    logic [POS_W:0]        pick_pos;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr0;
    logic [ADDR_W-1:0]     rd_addr1;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // Position arithmetic around the hole.
    assign left_pos   = {r_pos, 1'b0};
    assign right_pos  = left_pos + 1'b1;
    assign left_m1    = left_pos - 1'b1;
    assign pos_m1     = r_pos - 1'b1;
    assign parent_m1  = (r_pos >> 1) - 1'b1;
    assign req_pos_m1 = i_position - 1'b1;
    assign count_m1   = r_count - 1'b1;
    assign count_p1   = r_count + 1'b1;
    assign left_ok    = (left_pos <= {1'b0, r_count});
    assign right_ok   = (right_pos <= {1'b0, r_count});

    // Operation checks on the offered item.
    assign full    = (r_count == POS_W'(CAPACITY));
    assign empty   = (r_count == '0);
    assign pos_bad = (i_position == '0) || (i_position > r_count);

    // Order compares: "better" is smaller in min order, larger in max order.
    assign up_better  = r_order_max ? (r_val > r_rd0) : (r_val < r_rd0);
    assign right_pick = right_ok && (r_order_max ? (r_rd1 > r_rd0) : (r_rd1 < r_rd0));
    assign pick_data  = right_pick ? r_rd1 : r_rd0;
    assign pick_pos   = right_pick ? right_pos : left_pos;
    assign dn_better  = r_order_max ? (pick_data > r_val) : (pick_data < r_val);

    // Read address selection for both memory ports.
    always_comb begin
        rd_en    = i_cmd.accept | i_cmd.rd_up | i_cmd.rd_dn;
        rd_addr0 = req_pos_m1[ADDR_W-1:0];
        rd_addr1 = count_m1[ADDR_W-1:0];
        if (i_cmd.accept) begin
            rd_addr0 = (i_mode == bhpq_pkg::MODE_POP) ? '0 : req_pos_m1[ADDR_W-1:0];
        end else if (i_cmd.rd_up) begin
            rd_addr0 = parent_m1[ADDR_W-1:0];
        end else if (i_cmd.rd_dn) begin
            rd_addr0 = left_m1[ADDR_W-1:0];
            rd_addr1 = left_pos[ADDR_W-1:0];
        end
    end

    // Write into the hole: a moved neighbor or the travelling value.
    always_comb begin
        wr_en   = i_cmd.wr_val | i_cmd.up_step | i_cmd.dn_step;
        wr_addr = pos_m1[ADDR_W-1:0];
        if (i_cmd.up_step && up_better) begin
            wr_data = r_rd0;
        end else if (i_cmd.dn_step && dn_better) begin
            wr_data = pick_data;
        end else begin
            wr_data = r_val;
        end
    end

    // Entry memory with registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= mem[rd_addr0];
            r_rd1 <= mem[rd_addr1];
        end
    end

    // Order register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_max <= 1'b0;
        end else if (i_cfg_we) begin
            r_order_max <= i_cfg_wdata;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_mode == bhpq_pkg::MODE_INSERT && !full) begin
                r_count <= count_p1;
            end else if (i_mode == bhpq_pkg::MODE_CLEAR) begin
                r_count <= '0;
            end
        end else if (i_cmd.pop_load) begin
            r_count <= count_m1;
        end
    end

    // Hole position, travelling value and pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos <= count_p1;
            r_val <= i_value;
            r_res <= '0;
            case (i_mode)
                bhpq_pkg::MODE_INSERT:
                    r_status <= full ? bhpq_pkg::STAT_FULL_DROP : bhpq_pkg::STAT_OK;
                bhpq_pkg::MODE_POP:
                    r_status <= empty ? bhpq_pkg::STAT_EMPTY_POP : bhpq_pkg::STAT_OK;
                bhpq_pkg::MODE_READ:
                    r_status <= pos_bad ? bhpq_pkg::STAT_BAD_POS : bhpq_pkg::STAT_OK;
                default:
                    r_status <= bhpq_pkg::STAT_OK;
            endcase
        end else if (i_cmd.pop_load) begin
            r_res <= r_rd0;
            r_val <= r_rd1;
            r_pos <= POS_W'(1);
        end else if (i_cmd.rd_load) begin
            r_res <= r_rd0;
        end else if (i_cmd.up_step && up_better) begin
            r_pos <= r_pos >> 1;
        end else if (i_cmd.dn_step && dn_better) begin
            r_pos <= pick_pos[POS_W-1:0];
        end
    end

    // Output register holds one finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value  <= r_res;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

    // Status back to the controller.
    always_comb begin
        o_stat           = '0;
        o_stat.mode      = i_mode;
        o_stat.full      = full;
        o_stat.empty     = empty;
        o_stat.pos_bad   = pos_bad;
        o_stat.is_root   = (r_pos == POS_W'(1));
        o_stat.up_better = up_better;
        o_stat.count_one = (r_count == POS_W'(1));
        o_stat.left_ok   = left_ok;
        o_stat.dn_better = dn_better;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

// File: src/binary_heap_priority_queue.sv
// ============================================================================
// binary_heap_priority_queue
// Min or max binary heap with insert, pop root, read at position and clear.
// ============================================================================
// The heap works on one item at a time. An insert opens a hole at the next
// free position, then each level reads the parent and compares, moving the
// parent down or placing the value; a value that climbs to the root is placed
// there. A pop of a heap that keeps entries latches the root and the last
// entry, opens a hole at the root, then each level reads both children and
// compares with the better one, moving it up or placing the entry; an entry
// that reaches a position with no child is placed there. Each level costs one
// memory read and one compare-and-write. A valid read latches the entry, a pop
// of the only entry latches the root, and clear and rejected operations go
// straight to the result. The result waits while the output register holds an
// earlier result not yet taken. A new item is accepted in the cycle after the
// result enters the output register at the earliest, and the output register
// holds the result until it is taken. The entry memory has no reset and needs
// no clearing pass; the fill count alone decides what is held.
// ============================================================================
module binary_heap_priority_queue #(
    parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    bhpq_req_if.sink   i_req,
    bhpq_rsp_if.source o_rsp
);

    localparam int POS_W = $clog2(CAPACITY + 1);

    bhpq_pkg::t_dp_cmd  cmd;
    bhpq_pkg::t_dp_stat stat;

    // Operation sequencer.
    bhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage, compares and output register.
    bhpq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .POS_W      (POS_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_req.mode),
        .i_value        (i_req.value),
        .i_position     (i_req.position),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_entry_count  (o_rsp.entry_count),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule
